### rtl/core/sac_pkg.sv
// Shared types, constants and parser step functions for the signature arity counter.
package sac_pkg;

	localparam int MAX_NAME = 32;
	localparam int NAME_IDX_W = $clog2(MAX_NAME);
	localparam int NAME_LEN_W = $clog2(MAX_NAME + 1);
	localparam logic [7:0] NEST_MAX = 8'd255;
	localparam logic [7:0] COUNT_MAX = 8'd255;
	localparam logic [15:0] POS_MAX = 16'hFFFF;

	localparam logic [1:0] MODE_NAME = 2'd0;
	localparam logic [1:0] MODE_SIG = 2'd1;
	localparam logic [1:0] MODE_END = 2'd2;
	// unused code, dropped without a result
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam logic [1:0] OP_SIG = 2'd0;
	localparam logic [1:0] OP_END = 2'd1;
	localparam logic [1:0] OP_CLR = 2'd2;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [0:3][7:0] OPENS = {8'h28, 8'h5B, 8'h7B, 8'h3C};
	localparam logic [0:3][7:0] CLOSES = {8'h29, 8'h5D, 8'h7D, 8'h3E};

	localparam logic [0:7][7:0] K_SELF = {"self", 32'h0};
	localparam logic [0:7][7:0] K_SELFC = {"self:", 24'h0};
	localparam logic [0:7][7:0] K_CLS = {"cls", 40'h0};
	localparam logic [0:7][7:0] K_CLSC = {"cls:", 32'h0};
	localparam logic [0:7][7:0] K_RSELF = {"&self", 24'h0};
	localparam logic [0:7][7:0] K_RMSELF = "&mutself";

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] char_code;
	} in_item_t;

	typedef struct packed {
		logic       arity_known;
		logic [7:0] arity;
		logic       name_overflow;
	} out_item_t;

	// front to back operation
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
		logic [1:0] elig;
		logic       sel;
		logic       ovf;
	} op_t;

	typedef struct packed {
		logic             started;
		logic             done;
		logic             sq;
		logic             dq;
		logic             esc;
		logic             token;
		logic [0:3][7:0]  depth;
		logic [7:0]       count;
		logic [0:7][7:0]  prefix;
		logic [3:0]       plen;
		logic [7:0]       value;
	} parser_t;

	function automatic parser_t parser_init();
		parser_t p;
		p = '0;
		p.count = 8'd1;
		return p;
	endfunction

	function automatic logic prefix_is(parser_t p, logic [0:7][7:0] s, logic [3:0] n,
		logic exact);
		logic ok;
		ok = exact ? (p.plen == n) : (p.plen >= n);
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < n && p.prefix[i] != s[i]) ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic logic [7:0] finish_value(parser_t p);
		logic self_arg;
		self_arg = prefix_is(p, K_SELF, 4'd4, 1'b1) || prefix_is(p, K_SELFC, 4'd5, 1'b0) ||
			prefix_is(p, K_CLS, 4'd3, 1'b1) || prefix_is(p, K_CLSC, 4'd4, 1'b0) ||
			prefix_is(p, K_RSELF, 4'd5, 1'b0) || prefix_is(p, K_RMSELF, 4'd8, 1'b0);
		if (!p.token) return 8'd0;
		return self_arg ? p.count - 8'd1 : p.count;
	endfunction

	function automatic parser_t parser_byte(parser_t p, logic [7:0] c);
		parser_t n;
		logic top, tcomma, ws, hit;
		logic [7:0] lc;
		n = p;
		top = (p.depth == '0);
		tcomma = (c == CH_COMMA) && top;
		ws = (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
		lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + 8'd32 : c;
		hit = 1'b0;
		if (p.esc) begin
			n.esc = 1'b0;
		end else if (c == CH_BSLASH && (p.sq || p.dq)) begin
			n.esc = 1'b1;
		end else if (c == CH_SQUOTE && !p.dq) begin
			n.sq = !p.sq;
		end else if (c == CH_DQUOTE && !p.sq) begin
			n.dq = !p.dq;
		end else if (p.sq || p.dq) begin
			n.esc = 1'b0;
		end else if (c == CH_RPAREN && top) begin
			n.done = 1'b1;
			n.value = finish_value(p);
		end else begin
			if (!ws && !tcomma) begin
				n.token = 1'b1;
				if (p.count == 8'd1) begin
					if (p.plen < 4'd8) n.prefix[p.plen[2:0]] = lc;
					if (p.plen < 4'd9) n.plen = p.plen + 4'd1;
				end
			end
			for (int k = 0; k < 4; k++) begin
				if (!hit && c == OPENS[k]) begin
					hit = 1'b1;
					if (p.depth[k] < NEST_MAX) n.depth[k] = p.depth[k] + 8'd1;
				end else if (!hit && c == CLOSES[k] && p.depth[k] != 8'd0) begin
					hit = 1'b1;
					n.depth[k] = p.depth[k] - 8'd1;
				end
			end
			if (!hit && tcomma && p.count < COUNT_MAX) n.count = p.count + 8'd1;
		end
		return n;
	endfunction

endpackage

### rtl/core/signature_arity_counter.sv
// Top level of the signature arity counter: front, queue and back.
//
//   port group              dir  item
//   sig_valid/stall/item    in   in_item_t  (mode, char_code)
//   res_valid/stall/item    out  out_item_t (arity_known, arity, name_overflow)
//
// One item per cycle sustained while sig_stall is low.
// An end item's result passes through the queue entry and then the result register.
// Reset clears all control state at once; no clearing pass.
// sig_stall rises only when the queue is full, which happens when res_stall holds back an end.
module signature_arity_counter
	import sac_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sig_valid,
	output logic      sig_stall,
	input  in_item_t  sig_item,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res_item
);

	logic push, full, pop, nonempty;
	op_t push_op, head;

	sac_front u_front (
		.clk(clk), .arst_n(arst_n), .in_take(sig_valid && !full), .in_item(sig_item),
		.push(push), .push_op(push_op)
	);

	sac_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_op(push_op), .full(full),
		.pop(pop), .nonempty(nonempty), .head(head)
	);

	sac_back u_back (
		.clk(clk), .arst_n(arst_n), .nonempty(nonempty), .head(head), .pop(pop),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item)
	);

	assign sig_stall = full;

endmodule

### rtl/core/sac_front.sv
// Front end: name store, match window and classification of incoming items.
module sac_front
	import sac_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_take,
	input  in_item_t in_item,
	output logic     push,
	output op_t      push_op
);

	logic [7:0] name_q [MAX_NAME];
	logic [7:0] win_q [MAX_NAME];
	logic [7:0] win_n [MAX_NAME];
	logic [NAME_LEN_W-1:0] len_q;
	logic [15:0] pos_q, pos_n;
	logic matched_q, closed_q, ovf_q, same;
	logic [NAME_LEN_W-1:0] idx;

	always_comb begin
		win_n[0] = in_item.char_code;
		for (int i = 1; i < MAX_NAME; i++) win_n[i] = win_q[i-1];
		pos_n = (pos_q < POS_MAX) ? pos_q + 16'd1 : pos_q;
		same = 1'b1;
		idx = '0;
		for (int k = 0; k < MAX_NAME; k++) begin
			idx = len_q - NAME_LEN_W'(1) - NAME_LEN_W'(k);
			if (NAME_LEN_W'(k) < len_q && win_n[idx[NAME_IDX_W-1:0]] != name_q[k])
				same = 1'b0;
		end
	end

	always_comb begin
		push = 1'b0;
		push_op.op = OP_SIG;
		push_op.ch = in_item.char_code;
		push_op.elig = {matched_q, (pos_q >= 16'(len_q))};
		push_op.sel = matched_q && (len_q != '0);
		push_op.ovf = ovf_q;
		if (in_take) begin
			unique case (in_item.mode)
				MODE_NAME: begin
					push = closed_q;
					push_op.op = OP_CLR;
				end
				MODE_SIG: begin
					push = 1'b1;
				end
				MODE_END: begin
					push = 1'b1;
					push_op.op = OP_END;
				end
				default: push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && in_item.mode == MODE_NAME) begin
			if (closed_q) name_q[0] <= in_item.char_code;
			else if (len_q < NAME_LEN_W'(MAX_NAME))
				name_q[len_q[NAME_IDX_W-1:0]] <= in_item.char_code;
		end
		if (in_take && in_item.mode == MODE_SIG) begin
			for (int i = 0; i < MAX_NAME; i++) win_q[i] <= win_n[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			pos_q <= '0;
			matched_q <= 1'b0;
			closed_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (in_take) begin
			unique case (in_item.mode)
				MODE_NAME: begin
					if (closed_q) begin
						len_q <= NAME_LEN_W'(1);
						ovf_q <= 1'b0;
						closed_q <= 1'b0;
						pos_q <= '0;
						matched_q <= 1'b0;
					end else if (len_q < NAME_LEN_W'(MAX_NAME)) begin
						len_q <= len_q + NAME_LEN_W'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
				MODE_SIG: begin
					closed_q <= 1'b1;
					pos_q <= pos_n;
					if (!matched_q && len_q != '0 && pos_n >= 16'(len_q)) matched_q <= same;
				end
				MODE_END: begin
					closed_q <= 1'b1;
					pos_q <= '0;
					matched_q <= 1'b0;
				end
				default: closed_q <= closed_q;
			endcase
		end
	end

endmodule

### rtl/core/sac_queue.sv
// Two-entry queue of operations between front and back.
module sac_queue
	import sac_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output op_t  head
);

	op_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### rtl/core/sac_back.sv
// Back end: the two bracket parsers and the result register.
module sac_back
	import sac_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      nonempty,
	input  op_t       head,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res_item
);

	parser_t psr_q [2];
	parser_t chosen;
	logic out_valid_q;
	out_item_t out_q;

	assign pop = nonempty && (head.op != OP_END || !out_valid_q || !res_stall);
	assign res_valid = out_valid_q;
	assign res_item = out_q;
	assign chosen = psr_q[head.sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psr_q[0] <= parser_init();
			psr_q[1] <= parser_init();
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !res_stall) out_valid_q <= 1'b0;
			if (pop) begin
				unique case (head.op)
					OP_SIG: begin
						for (int k = 0; k < 2; k++) begin
							if (!psr_q[k].started) begin
								if (head.elig[k] && head.ch == CH_LPAREN)
									psr_q[k].started <= 1'b1;
							end else if (!psr_q[k].done) begin
								psr_q[k] <= parser_byte(psr_q[k], head.ch);
							end
						end
					end
					OP_END: begin
						out_valid_q <= 1'b1;
						psr_q[0] <= parser_init();
						psr_q[1] <= parser_init();
					end
					default: begin
						psr_q[0] <= parser_init();
						psr_q[1] <= parser_init();
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.op == OP_END) begin
			out_q.arity_known <= chosen.done;
			out_q.arity <= chosen.done ? chosen.value : 8'd0;
			out_q.name_overflow <= head.ovf;
		end
	end

endmodule

### verif/tb_signature_arity_counter.sv
// Testbench for the signature arity counter: random and directed byte streams, scoreboard check.
module tb_signature_arity_counter;
	timeunit 1ns;
	timeprecision 1ps;
	import sac_pkg::*;

	typedef struct {
		logic started, done, sq, dq, esc, token;
		logic [7:0] depth [4];
		logic [7:0] count;
		logic [7:0] prefix [8];
		logic [3:0] plen;
		logic [7:0] value;
	} list_parse_t;

	class arity_scoreboard;
		out_item_t pending_arities[$];
		logic [7:0] name_bytes [MAX_NAME];
		int name_len;
		logic [7:0] window [MAX_NAME];
		int position;
		logic matched, name_closed, ovf;
		list_parse_t lists [2];
		int mismatches;

		function void clear_list(int k);
			lists[k].started = 0; lists[k].done = 0; lists[k].sq = 0; lists[k].dq = 0;
			lists[k].esc = 0; lists[k].token = 0; lists[k].count = 1;
			lists[k].plen = 0; lists[k].value = 0;
			for (int i = 0; i < 4; i++) lists[k].depth[i] = 0;
			for (int i = 0; i < 8; i++) lists[k].prefix[i] = 0;
		endfunction

		function void clear_signature();
			for (int i = 0; i < MAX_NAME; i++) window[i] = 0;
			position = 0;
			matched = 0;
			clear_list(0);
			clear_list(1);
		endfunction

		function void reset_state();
			name_len = 0; name_closed = 0; ovf = 0; mismatches = 0;
			for (int i = 0; i < MAX_NAME; i++) name_bytes[i] = 0;
			clear_signature();
		endfunction

		function logic starts_with(int k, string s, bit exact);
			if (exact ? lists[k].plen != s.len() : lists[k].plen < s.len()) return 0;
			for (int i = 0; i < s.len(); i++)
				if (lists[k].prefix[i] != s[i]) return 0;
			return 1;
		endfunction

		function void close_list(int k);
			lists[k].done = 1;
			if (!lists[k].token) lists[k].value = 0;
			else if (starts_with(k, "self", 1) || starts_with(k, "self:", 0) ||
				starts_with(k, "cls", 1) || starts_with(k, "cls:", 0) ||
				starts_with(k, "&self", 0) || starts_with(k, "&mutself", 0))
				lists[k].value = lists[k].count - 8'd1;
			else
				lists[k].value = lists[k].count;
		endfunction

		function void list_byte(int k, logic [7:0] c);
			logic top, tcomma;
			logic [7:0] lc;
			if (lists[k].esc) begin lists[k].esc = 0; return; end
			if (c == "\\" && (lists[k].sq || lists[k].dq)) begin lists[k].esc = 1; return; end
			if (c == "'" && !lists[k].dq) begin lists[k].sq = !lists[k].sq; return; end
			if (c == "\"" && !lists[k].sq) begin lists[k].dq = !lists[k].dq; return; end
			if (lists[k].sq || lists[k].dq) return;
			top = lists[k].depth[0] == 0 && lists[k].depth[1] == 0 &&
				lists[k].depth[2] == 0 && lists[k].depth[3] == 0;
			if (c == ")" && top) begin close_list(k); return; end
			tcomma = c == "," && top;
			if (!(c == " " || (c >= 9 && c <= 13)) && !tcomma) begin
				lists[k].token = 1;
				if (lists[k].count == 1) begin
					lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
					if (lists[k].plen < 8) lists[k].prefix[lists[k].plen] = lc;
					if (lists[k].plen < 9) lists[k].plen++;
				end
			end
			for (int i = 0; i < 4; i++) begin
				if (c == OPENS[i]) begin
					if (lists[k].depth[i] < NEST_MAX) lists[k].depth[i]++;
					return;
				end
				if (c == CLOSES[i] && lists[k].depth[i] > 0) begin
					lists[k].depth[i]--;
					return;
				end
			end
			if (tcomma && lists[k].count < COUNT_MAX) lists[k].count++;
		endfunction

		function void note_input(in_item_t it);
			logic elig [2];
			logic same;
			out_item_t r;
			int k;
			case (it.mode)
			MODE_NAME: begin
				if (name_closed) begin
					name_len = 0; ovf = 0; name_closed = 0;
					clear_signature();
				end
				if (name_len < MAX_NAME) name_bytes[name_len++] = it.char_code;
				else ovf = 1;
			end
			MODE_SIG: begin
				name_closed = 1;
				elig[0] = position >= name_len;
				elig[1] = matched;
				for (k = 0; k < 2; k++) begin
					if (!lists[k].started) begin
						if (elig[k] && it.char_code == "(") lists[k].started = 1;
					end else if (!lists[k].done) begin
						list_byte(k, it.char_code);
					end
				end
				for (k = MAX_NAME - 1; k > 0; k--) window[k] = window[k - 1];
				window[0] = it.char_code;
				if (position < 65535) position++;
				if (!matched && name_len > 0 && position >= name_len) begin
					same = 1;
					for (k = 0; k < name_len; k++)
						if (window[name_len - 1 - k] != name_bytes[k]) same = 0;
					matched = same;
				end
			end
			MODE_END: begin
				k = (matched && name_len > 0) ? 1 : 0;
				name_closed = 1;
				r.arity_known = lists[k].done;
				r.arity = lists[k].done ? lists[k].value : 8'd0;
				r.name_overflow = ovf;
				pending_arities = {pending_arities, r};
				clear_signature();
			end
			default: ;
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_arities.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			want = pending_arities.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
			end
		endfunction
	endclass

	logic clk, arst_n, sig_valid, sig_stall, res_valid, res_stall;
	in_item_t sig_item;
	out_item_t res_item;
	arity_scoreboard sb;
	int cycles;
	bit hold_off;

	signature_arity_counter u_top (.*);

	initial clk = 0;
	always #6 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// one transfer, with an optional random gap before it
	task automatic send(logic [1:0] mode, logic [7:0] c, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		repeat (g) begin
			sig_valid <= 0;
			@(posedge clk);
		end
		sig_valid <= 1;
		sig_item <= '{mode: mode, char_code: c};
		@(posedge clk);
		while (sig_stall) @(posedge clk);
		sb.note_input('{mode: mode, char_code: c});
	endtask

	task automatic send_str(logic [1:0] mode, string s, bit gaps);
		for (int i = 0; i < s.len(); i++) send(mode, s[i], gaps);
	endtask

	function automatic string pick(string opts[$]);
		return opts[$urandom_range(0, opts.size() - 1)];
	endfunction

	// signature-like text with random content; mostly well formed
	function automatic string rand_sig(string nm);
		string s, p;
		int n;
		s = "";
		if ($urandom_range(0, 3) == 0) s = pick('{"def ", "fn ", "pub fn ", "x "});
		if ($urandom_range(0, 4) != 0) s = {s, nm};
		s = {s, pick('{"(", "(", "(", "<T>(", " ("})};
		n = $urandom_range(0, 5);
		for (int i = 0; i < n; i++) begin
			p = pick('{"self", "Self", "cls", "cls: type", "&self", "&mut self",
				"&mutself", "a", "b: int", "x: List[int, str]", "d={1:2, 3:4}",
				"s='a,b'", "q=\"x\\\",y\"", "f=g(1, 2)", "m: Map<K, V>", " ",
				"\t", "c: str = ')'", "verylongparam: int"});
			s = {s, p};
			if (i != n - 1) s = {s, pick('{",", ", ", " ,"})};
		end
		if ($urandom_range(0, 7) != 0) s = {s, ")"};
		if ($urandom_range(0, 2) == 0) s = {s, pick('{" -> int:", ":", " {", ") (y)"})};
		return s;
	endfunction

	// receiver: random stalls, one long hold-off while the sender keeps going
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 0;
		end else if (hold_off) begin
			res_stall <= 1;
		end else begin
			res_stall <= ($urandom_range(0, 99) < 20) ? 1'b1 : ($urandom_range(0, 99) < 2);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) sb.check_result(res_item);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("tb_signature_arity_counter: errors");
			$finish;
		end
	end

	initial begin
		string nm, sg;
		int items, drain;
		cycles = 0;
		hold_off = 0;
		sb = new();
		sb.reset_state();
		arst_n = 0;
		sig_valid = 0;
		sig_item = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: self forms, empty list, quotes, no paren, long name, unused mode
		send_str(MODE_NAME, "foo", 0);
		send_str(MODE_SIG, "def foo(self, a, b)", 0);
		send(MODE_END, 8'h00, 0);
		send_str(MODE_SIG, "bar(x) foo(&mut self,y)", 0);
		send(MODE_END, 8'h00, 0);
		send_str(MODE_SIG, "foo()", 0);
		send(MODE_END, 8'h00, 0);
		send_str(MODE_SIG, "foo(s='\\',(', [1,2])", 0);
		send(MODE_END, 8'h00, 0);
		send_str(MODE_SIG, "no parens", 0);
		send(MODE_END, 8'h00, 0);
		send(MODE_SPARE, 8'hFF, 0);
		send_str(MODE_NAME, "abcdefghijklmnopqrstuvwxyz0123456789", 0);
		send_str(MODE_SIG, "q(CLS: int, ]a, b", 0);
		send(MODE_END, 8'h00, 0);
		send(MODE_SIG, 8'hFF, 0);
		send(MODE_END, 8'h00, 0);

		// long hold-off: block fills and stalls its input
		hold_off = 1;
		fork
			begin
				repeat (40) @(posedge clk);
				hold_off = 0;
			end
			begin
				for (int i = 0; i < 6; i++) begin
					send_str(MODE_SIG, "(a,b)", 0);
					send(MODE_END, 8'h00, 0);
				end
			end
		join

		items = 0;
		while (items < 1650) begin
			nm = "";
			if ($urandom_range(0, 9) != 0)
				nm = pick('{"foo", "f", "run", "init", "x", "Parse_It", "ab"});
			if ($urandom_range(0, 40) == 0)
				for (int i = 0; i < 34; i++) nm = {nm, "n"};
			for (int i = 0; i < nm.len(); i++) begin
				send(MODE_NAME, nm[i], 1);
				items++;
			end
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 5) == 0) begin
					// raw noise bytes, all bit values
					repeat ($urandom_range(1, 12)) begin
						send(MODE_SIG, 8'($urandom_range(0, 255)), 1);
						items++;
					end
				end else begin
					sg = rand_sig(nm);
					send_str(MODE_SIG, sg, 1);
					items += sg.len();
				end
				if ($urandom_range(0, 15) == 0) begin
					send(MODE_SPARE, 8'($urandom_range(0, 255)), 1);
					items++;
				end
				send(MODE_END, 8'($urandom_range(0, 255)), 1);
				items++;
			end
		end
		sig_valid <= 0;

		drain = 0;
		while (sb.pending_arities.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_arities.size() == 0)
			$display("tb_signature_arity_counter: clean");
		else
			$display("tb_signature_arity_counter: errors");
		$finish;
	end
endmodule

### sim.f
rtl/core/sac_pkg.sv
rtl/core/sac_front.sv
rtl/core/sac_queue.sv
rtl/core/sac_back.sv
rtl/core/signature_arity_counter.sv
verif/tb_signature_arity_counter.sv
